// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; modules that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property on an explicit clock, disabled while the active-low reset is low
`define ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property on the module's default clock and reset names
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_DEF(label, prop, msg)

`endif

`endif

// ===== rtl/bca_pkg.sv =====
// Types, codes and sizes of the block chain allocator.
// Used by the top level; no dependencies.
package bca_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 1'd1;

  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 13'd4096;
  localparam logic [CFG_W-1:0] RESERVED_RST    = 13'd8;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_LINK = 2'd1,
    KIND_EOC  = 2'd2,
    KIND_SYS  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_FORMAT   = 3'd0,
    CMD_ALLOC    = 3'd1,
    CMD_EXTEND   = 3'd2,
    CMD_NEXT     = 3'd3,
    CMD_TRUNCATE = 3'd4,
    CMD_RELEASE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_CHAIN = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] block;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_block;
    logic [1:0]  result_kind;
  } out_t;

  // One table entry
  typedef struct packed {
    kind_e            kind;
    logic [BLK_W-1:0] link;
  } entry_t;

endpackage

// ===== rtl/bca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/block_chain_allocator.sv =====
// Top level of the block chain allocator: command sequencer and table RAM.
// Depends on bca_pkg, bca_ram and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid / stall   | bca_pkg::in_t (cmd, block)
//   out     | from block| out_valid / stall  | bca_pkg::out_t (status, block, kind)
//   cfg     | to block  | cfg_valid / ready  | index, 13-bit data
//
// One command at a time, from its acceptance until its result raises out_valid_o.
// FORMAT sweeps every entry, one per cycle.
// ALLOC scans from entry 0 one per cycle for the lowest free index, to the end on a full table; EXTEND adds a write.
// TRUNCATE and RELEASE free one entry per cycle along the chain; NEXT reads one entry; range errors finish at once.
// Reset leaves the table undefined until the first FORMAT; control and configuration registers take their defaults.
// A new command is taken while a result still waits at the output register.
`include "assert_macros.svh"

module block_chain_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bca_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bca_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bca_pkg::CFG_W-1:0]      cfg_data_i
);
  import bca_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FMT  = 8'b0000_0010,
    S_FIND = 8'b0000_0100,
    S_EXTW = 8'b0000_1000,
    S_NEXT = 8'b0001_0000,
    S_WALK = 8'b0010_0000,
    S_TRNW = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   blk_cnt_q, blk_cnt_d;
  logic [CFG_W-1:0]   rsv_q, rsv_d;
  logic [2:0]         cmd_q, cmd_d;
  logic [BLK_W-1:0]   blk_q, blk_d;
  logic [BLK_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               pend_q, pend_d;
  logic [BLK_W-1:0]   pend_addr_q, pend_addr_d;
  logic [BLK_W-1:0]   fmt_q, fmt_d;
  logic               fwd_q, fwd_d;
  logic [BLK_W-1:0]   found_q, found_d;
  out_t               res_q, res_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               ram_we, ram_re;
  logic [BLK_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic [CNT_W-1:0]   n_c;
  logic [CNT_W-1:0]   sys_lim_c;
  logic               in_acc, walk_done;
  logic               in_range;
  kind_e              walk_kind;

  // Entries in use and the system limit for FORMAT
  assign n_c       = (blk_cnt_q < CNT_W'(NUM_BLOCKS)) ? blk_cnt_q : CNT_W'(NUM_BLOCKS);
  assign sys_lim_c = (rsv_q < n_c) ? rsv_q : n_c;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_range    = ({1'b0, in_data_i.block} < n_c);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rd_entry    = entry_t'(ram_rdata);
  // The read that met a same-cycle write of the same entry sees it freed
  assign walk_kind   = fwd_q ? KIND_FREE : rd_entry.kind;

  // Configuration registers
  always_comb begin
    blk_cnt_d = blk_cnt_q;
    rsv_d     = rsv_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BLOCK_COUNT: blk_cnt_d = cfg_data_i;
        REG_RESERVED:    rsv_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command sequencer: read, modify and write back the table
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    blk_d       = blk_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    fmt_d       = fmt_q;
    fwd_d       = 1'b0;
    found_d     = found_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = blk_q;
    ram_wdata   = '{kind: KIND_FREE, link: '0};
    ram_re      = 1'b0;
    ram_raddr   = cur_q;
    walk_done   = 1'b0;

    // Drop the output once it is transferred
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = in_data_i.cmd;
          blk_d   = in_data_i.block;
          res_d   = '0;
          scan_d  = '0;
          pend_d  = 1'b0;
          steps_d = '0;
          fmt_d   = '0;
          cur_d   = in_data_i.block;
          case (in_data_i.cmd)
            CMD_FORMAT: state_d = S_FMT;
            CMD_ALLOC:  state_d = S_FIND;
            CMD_EXTEND: begin
              if (in_range) begin
                state_d = S_FIND;
              end else begin
                res_d.status = ST_RANGE;
                state_d      = S_FIN;
              end
            end
            CMD_NEXT, CMD_TRUNCATE, CMD_RELEASE: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = in_data_i.block;
                state_d   = (in_data_i.cmd == CMD_NEXT) ? S_NEXT : S_WALK;
              end else begin
                res_d.status = ST_RANGE;
                state_d      = S_FIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // Clear every entry, marking the low ones as system
      S_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = fmt_q;
        ram_wdata = '{kind: ({1'b0, fmt_q} < sys_lim_c) ? KIND_SYS : KIND_FREE, link: '0};
        if (fmt_q == BLK_W'(NUM_BLOCKS - 1)) begin
          state_d = S_FIN;
        end else begin
          fmt_d = fmt_q + 1'b1;
        end
      end

      // Scan for the lowest free entry, one read issued per cycle
      S_FIND: begin
        if (pend_q && (rd_entry.kind == KIND_FREE)) begin
          res_d.result_block = pend_addr_q;
          ram_we             = 1'b1;
          if (cmd_q == CMD_EXTEND) begin
            ram_waddr = blk_q;
            ram_wdata = '{kind: KIND_LINK, link: pend_addr_q};
            found_d   = pend_addr_q;
            state_d   = S_EXTW;
          end else begin
            ram_waddr = pend_addr_q;
            ram_wdata = '{kind: KIND_EOC, link: '0};
            state_d   = S_FIN;
          end
        end else if (!pend_q && (scan_q >= n_c)) begin
          res_d.status = ST_FULL;
          if (cmd_q == CMD_EXTEND) begin
            ram_we    = 1'b1;
            ram_waddr = blk_q;
            ram_wdata = '{kind: KIND_EOC, link: '0};
          end
          state_d = S_FIN;
        end else if (scan_q < n_c) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_q[BLK_W-1:0];
          scan_d      = scan_q + 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = scan_q[BLK_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end

      // Mark the new block end of chain after linking the tail
      S_EXTW: begin
        ram_we    = 1'b1;
        ram_waddr = found_q;
        ram_wdata = '{kind: KIND_EOC, link: '0};
        state_d   = S_FIN;
      end

      S_NEXT: begin
        res_d.result_kind = rd_entry.kind;
        if (rd_entry.kind == KIND_LINK) begin
          res_d.result_block = rd_entry.link;
        end
        state_d = S_FIN;
      end

      // Free the chain, one link per cycle
      S_WALK: begin
        ram_waddr = cur_q;
        if (walk_kind == KIND_EOC) begin
          ram_we    = 1'b1;
          walk_done = 1'b1;
        end else if (walk_kind != KIND_LINK) begin
          res_d.status = ST_CHAIN;
          walk_done    = 1'b1;
        end else if (steps_q >= n_c) begin
          res_d.status = ST_CHAIN;
          walk_done    = 1'b1;
        end else begin
          ram_we  = 1'b1;
          steps_d = steps_q + 1'b1;
          if ({1'b0, rd_entry.link} >= n_c) begin
            res_d.status = ST_CHAIN;
            walk_done    = 1'b1;
          end else begin
            cur_d     = rd_entry.link;
            ram_re    = 1'b1;
            ram_raddr = rd_entry.link;
            fwd_d     = (rd_entry.link == cur_q);
          end
        end
        if (walk_done) begin
          state_d = (cmd_q == CMD_TRUNCATE) ? S_TRNW : S_FIN;
        end
      end

      // Keep the start block as end of chain
      S_TRNW: begin
        ram_we    = 1'b1;
        ram_waddr = blk_q;
        ram_wdata = '{kind: KIND_EOC, link: '0};
        state_d   = S_FIN;
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blk_cnt_q   <= BLOCK_COUNT_RST;
      rsv_q       <= RESERVED_RST;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_cnt_q   <= blk_cnt_d;
      rsv_q       <= rsv_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      fwd_q       <= fwd_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    blk_q       <= blk_d;
    cur_q       <= cur_d;
    steps_q     <= steps_d;
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
    fmt_q       <= fmt_d;
    found_q     <= found_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  bca_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  `ASSERT_DEF(a_out_from_fin, $rose(out_valid_o) |-> $past(state_q == S_FIN), "stray result")
  `ASSERT_DEF(a_no_write_idle, ram_we |-> !(state_q == S_IDLE || state_q == S_FIN), "idle write")
  `ASSERT_DEF(a_fwd_in_walk, fwd_q |-> (state_q == S_WALK), "forward flag outside chain walk")
  `ASSERT_DEF(a_accept_busy, in_acc |=> (state_q != S_IDLE), "accepted command dropped")

endmodule

// ===== test/bca_checker.sv =====
// Checker for the block chain allocator: watches the command, result and register channels,
// keeps its own copy of the allocation table and compares every result transfer.
// Depends on bca_pkg for the payload types, codes and register indexes.
`timescale 1ns / 1ps

module bca_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  bca_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  bca_pkg::out_t                  out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bca_pkg::CFG_W-1:0]      cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import bca_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the table and of the two registers
  kind_e            entry_kind [NUM_BLOCKS];
  logic [BLK_W-1:0] entry_link [NUM_BLOCKS];
  int               block_count;
  int               reserved_blocks;

  out_t expected_results [$];
  int   mismatch_count;
  int   outstanding;

  assign fail_count_o = mismatch_count;
  assign pending_o    = outstanding;

  function automatic void set_entry(int idx, kind_e kind, logic [BLK_W-1:0] link);
    entry_kind[idx] = kind;
    entry_link[idx] = link;
  endfunction

  // Lowest free entry below n, or n when the table is full
  function automatic int lowest_free(int n);
    int idx;
    idx = 0;
    while (idx < n && entry_kind[idx] != KIND_FREE) idx++;
    return idx;
  endfunction

  // Free the chain from start; report whether the walk broke off
  function automatic bit chain_broken(int start, int n);
    int cur;
    int steps;
    int nxt;
    bit done;
    bit broken;
    cur = start;
    steps = 0;
    done = 0;
    broken = 0;
    while (!done) begin
      if (cur >= n) begin
        broken = 1;
        done = 1;
      end else if (entry_kind[cur] == KIND_EOC) begin
        set_entry(cur, KIND_FREE, '0);
        done = 1;
      end else if (entry_kind[cur] != KIND_LINK) begin
        broken = 1;
        done = 1;
      end else begin
        steps++;
        if (steps > n) begin
          broken = 1;
          done = 1;
        end else begin
          nxt = int'(entry_link[cur]);
          set_entry(cur, KIND_FREE, '0);
          cur = nxt;
        end
      end
    end
    return broken;
  endfunction

  // Apply one command to the shadow table and return the result it must give
  function automatic out_t predict_result(in_t item);
    int   n;
    int   f;
    int   idx;
    int   blk;
    out_t res;
    n   = (block_count < NUM_BLOCKS) ? block_count : NUM_BLOCKS;
    blk = int'(item.block);
    res = '0;
    case (item.cmd)
      CMD_FORMAT: begin
        for (idx = 0; idx < NUM_BLOCKS; idx++) begin
          if (idx < n && idx < reserved_blocks) set_entry(idx, KIND_SYS, '0);
          else set_entry(idx, KIND_FREE, '0);
        end
      end
      CMD_ALLOC: begin
        f = lowest_free(n);
        if (f < n) begin
          set_entry(f, KIND_EOC, '0);
          res.result_block = BLK_W'(f);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_EXTEND: begin
        if (blk >= n) begin
          res.status = ST_RANGE;
        end else begin
          f = lowest_free(n);
          if (f < n) begin
            // a free tail is its own lowest free block: link first, then end it
            set_entry(blk, KIND_LINK, BLK_W'(f));
            set_entry(f, KIND_EOC, '0);
            res.result_block = BLK_W'(f);
          end else begin
            set_entry(blk, KIND_EOC, '0);
            res.status = ST_FULL;
          end
        end
      end
      CMD_NEXT: begin
        if (blk >= n) begin
          res.status = ST_RANGE;
        end else begin
          res.result_kind = entry_kind[blk];
          if (entry_kind[blk] == KIND_LINK) res.result_block = entry_link[blk];
        end
      end
      CMD_TRUNCATE, CMD_RELEASE: begin
        if (blk >= n) begin
          res.status = ST_RANGE;
        end else begin
          if (chain_broken(blk, n)) res.status = ST_CHAIN;
          if (item.cmd == CMD_TRUNCATE) set_entry(blk, KIND_EOC, '0);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Watch the three channels; a new command is predicted before any result is matched
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   idx;
    if (!rst_ni) begin
      for (idx = 0; idx < NUM_BLOCKS; idx++) set_entry(idx, KIND_FREE, '0);
      block_count     = int'(BLOCK_COUNT_RST);
      reserved_blocks = int'(RESERVED_RST);
      expected_results.delete();
      mismatch_count  = 0;
      outstanding     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_BLOCK_COUNT) block_count = int'(cfg_data_i);
        else if (cfg_index_i == REG_RESERVED) reserved_blocks = int'(cfg_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(predict_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result transfer with nothing outstanding: %s %0d block %0d kind %0d",
                     $realtime, "status", out_data_i.status, out_data_i.result_block,
                     out_data_i.result_kind);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.result_block !== want.result_block ||
              out_data_i.result_kind !== want.result_kind) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result differs: status %0d/%0d block %0d/%0d %s %0d/%0d",
                       $realtime, want.status, out_data_i.status, want.result_block,
                       out_data_i.result_block, "kind", want.result_kind,
                       out_data_i.result_kind);
          end
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the allocator testbench: clock, reset, command and register stimulus, result stalls.
// Depends on bca_pkg, block_chain_allocator and bca_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb;
  import bca_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 600;

  // Command codes the block does not implement
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Receiver stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_TOGGLE = 3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int cur_count;
  int cur_reserved;
  int burst_left;
  int cycles;
  bit hold_req;
  bit hold_done;

  block_chain_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bca_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous number of cycles
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: switch between stall patterns, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(STALL_TOGGLE, STALL_NONE);
          mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(99, 0) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(99, 0) < 75);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offer one command and hold it until the transfer
  task automatic send_cmd(logic [2:0] cmd, logic [11:0] blk);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, block: blk};
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_gap(int len);
    if (len > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    idle_gap(1);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once every result has come back
  task automatic set_config(int count, int reserved);
    wait_drained();
    write_reg(REG_BLOCK_COUNT, CFG_W'(count));
    write_reg(REG_RESERVED, CFG_W'(reserved));
    cur_count    = count;
    cur_reserved = reserved;
  endtask

  // Mostly well-formed traffic, a little format and some unused codes
  function automatic logic [2:0] pick_cmd();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 3) return CMD_FORMAT;
    if (sel < 28) return CMD_ALLOC;
    if (sel < 52) return CMD_EXTEND;
    if (sel < 70) return CMD_NEXT;
    if (sel < 81) return CMD_TRUNCATE;
    if (sel < 93) return CMD_RELEASE;
    return $urandom_range(1, 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // Aim mostly at the blocks just above the reserved area, where chains live
  function automatic logic [11:0] pick_block();
    int sel;
    int n;
    int base;
    int lo;
    int hi;
    n    = (cur_count < NUM_BLOCKS) ? cur_count : NUM_BLOCKS;
    base = (cur_reserved < n) ? cur_reserved : n;
    sel  = $urandom_range(99, 0);
    if (sel < 70) begin
      lo = (base >= 2) ? base - 2 : 0;
      hi = base + 24;
      if (hi > n - 1) hi = n - 1;
      if (lo > hi) lo = hi;
      return 12'($urandom_range(hi, lo));
    end
    if (sel < 82) return 12'($urandom_range(n - 1, 0));
    if (sel < 94) return 12'($urandom());
    return 12'((n <= 4095) ? n : 4095);
  endfunction

  task automatic random_phase(int count, int reserved, int items, bit fmt, bit hold);
    int idx;
    set_config(count, reserved);
    if (fmt) send_cmd(CMD_FORMAT, '0);
    for (idx = 0; idx < items; idx++) begin
      // start a new burst, usually after a gap
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 1);
        if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(8, 1));
      end
      if (hold && idx == items / 3) hold_req = 1;
      send_cmd(pick_cmd(), pick_block());
      burst_left--;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_req     = 0;
    burst_left   = 0;
    cur_count    = int'(BLOCK_COUNT_RST);
    cur_reserved = int'(RESERVED_RST);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Default registers: build and walk a few chains
    send_cmd(CMD_FORMAT, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_EXTEND, 12'd8);
    send_cmd(CMD_NEXT, 12'd8);
    send_cmd(CMD_NEXT, 12'd9);
    send_cmd(CMD_NEXT, 12'd0);
    send_cmd(CMD_NEXT, 12'd4095);
    // free tail that is itself the lowest free block
    send_cmd(CMD_EXTEND, 12'd10);
    // system tail is overwritten
    send_cmd(CMD_EXTEND, 12'd3);
    send_cmd(CMD_RELEASE, 12'd9);
    // dangling link into a freed block
    send_cmd(CMD_RELEASE, 12'd8);
    send_cmd(CMD_TRUNCATE, 12'd3);
    send_cmd(CMD_RELEASE, 12'd0);
    send_cmd(CMD_SPARE_LO, 12'd4095);
    send_cmd(CMD_SPARE_HI, 12'd0);

    // Link that points past a shrunk block count
    set_config(4096, 20);
    send_cmd(CMD_FORMAT, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_EXTEND, 12'd5);
    set_config(16, 4);
    send_cmd(CMD_NEXT, 12'd5);
    send_cmd(CMD_RELEASE, 12'd5);
    // out of range for every command that takes a block
    send_cmd(CMD_EXTEND, 12'd16);
    send_cmd(CMD_NEXT, 12'd4095);
    send_cmd(CMD_TRUNCATE, 12'd16);
    send_cmd(CMD_RELEASE, 12'd4095);

    // Random traffic over several register settings
    random_phase(16, 0, 150, 1, 0);
    random_phase(16, 4096, 20, 1, 0);
    random_phase(4096, 0, 150, 0, 1);
    random_phase(37, 5, 150, 0, 0);
    random_phase(300, 255, 60, 1, 0);
    random_phase(3968, 3, 150, 0, 0);
    random_phase(100, 90, 150, 1, 0);
    random_phase(23, 1, 120, 0, 0);
    random_phase(4096, 4096, 8, 1, 0);
    random_phase(4096, 8, 60, 1, 0);

    // Drain, let the block settle, then give the verdict
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
